// ===== rtl/bsa_pkg.sv =====
package bsa_pkg;

  // Page geometry
  localparam int MAX_SLOTS  = 512;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIT_AW     = $clog2(WORD_BITS);

  // Internal width for counts and slot numbers (at least the register width)
  localparam int CNT_MIN_W  = $clog2(MAX_SLOTS + 1);
  localparam int CW         = (CNT_MIN_W > 10) ? CNT_MIN_W : 10;

  // Port field widths
  localparam int SLOT_COUNT_W = 10;
  localparam int SLOT_IDX_W   = 9;
  localparam int STATUS_W     = 2;

  // Request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSLOT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DBLFREE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd3;

  // Bitmap read address select
  localparam logic [1:0] RD_HINT  = 2'd0;
  localparam logic [1:0] RD_IDX   = 2'd1;
  localparam logic [1:0] RD_SCAN0 = 2'd2;
  localparam logic [1:0] RD_NEXT  = 2'd3;

  // Datapath actions that end a transaction
  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_ERR_NOSLOT = 3'd1;
  localparam logic [2:0] ACT_ERR_FREE   = 3'd2;
  localparam logic [2:0] ACT_ERR_RANGE  = 3'd3;
  localparam logic [2:0] ACT_ALLOC_HINT = 3'd4;
  localparam logic [2:0] ACT_ALLOC_SCAN = 3'd5;
  localparam logic [2:0] ACT_FREE       = 3'd6;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;       // latch the request fields
    logic [1:0] rd_sel;     // which word to read
    logic       hint_clr;   // consume the one-shot hint
    logic       scan_rst;   // scan pointer to word zero
    logic       scan_step;  // advance scan pointer
    logic [2:0] act;        // final action of the transaction
    logic       out_ld;     // move result into the output register
  } bsa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic op;             // latched request code
    logic alloc_blocked;  // no free slot or dead page
    logic range_err;      // free index not below the slot count
    logic hint_valid;
    logic hint_in_range;
    logic bit_used;       // addressed bit in the word just read
    logic word_full;      // word just read has no clear bit
    logic scan_in_range;  // lowest clear bit of that word is below the count
    logic scan_last;      // scan pointer at the last word
  } bsa_status_t;

  // Register value clamped to 1..MAX_SLOTS
  function automatic logic [CW-1:0] eff_count(input logic [SLOT_COUNT_W-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w == '0) begin
      eff_count = CW'(1);
    end else if (w > CW'(MAX_SLOTS)) begin
      eff_count = CW'(MAX_SLOTS);
    end else begin
      eff_count = w;
    end
  endfunction

endpackage

// ===== rtl/bsa_ram.sv =====
module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/bsa_dp.sv =====
module bsa_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [bsa_pkg::SLOT_COUNT_W-1:0]    cfg_wr_data,
  input  logic                                in_op,
  input  logic [bsa_pkg::SLOT_IDX_W-1:0]      in_slot_index,
  input  logic                                in_sole_in_list,
  input  bsa_pkg::bsa_cmd_t                   cmd,
  output bsa_pkg::bsa_status_t                st,
  output logic [bsa_pkg::STATUS_W-1:0]        out_status,
  output logic [bsa_pkg::SLOT_IDX_W-1:0]      out_granted_index,
  output logic                                out_keep_page,
  output logic                                out_left_pool,
  output logic                                out_rejoined_pool,
  output logic [bsa_pkg::SLOT_COUNT_W-1:0]    out_free_count
);

  localparam int CW = bsa_pkg::CW;
  localparam int AW = bsa_pkg::WORD_AW;
  localparam int BW = bsa_pkg::BIT_AW;
  localparam int WB = bsa_pkg::WORD_BITS;

  // Page state
  logic [CW-1:0]                    count_r;
  logic [CW-1:0]                    avail_r;
  logic [CW-1:0]                    hint_r;
  logic                             hint_valid_r;
  logic                             alive_r;
  logic [bsa_pkg::WORD_COUNT-1:0]   wvalid_r;
  logic [AW-1:0]                    scan_w_r;
  logic                             rvld_r;

  // Latched request
  logic          op_r;
  logic [CW-1:0] idx_r;
  logic          sole_r;

  // Result and output registers
  logic [bsa_pkg::STATUS_W-1:0]     res_status_r, out_status_r;
  logic [bsa_pkg::SLOT_IDX_W-1:0]   res_granted_r, out_granted_r;
  logic                             res_keep_r, out_keep_r;
  logic                             res_left_r, out_left_r;
  logic                             res_rejoin_r, out_rejoin_r;
  logic [bsa_pkg::SLOT_COUNT_W-1:0] res_free_r, out_free_r;

  // Bitmap port
  logic          ram_we;
  logic [AW-1:0] ram_addr, rd_addr, wr_addr;
  logic [WB-1:0] ram_wdata, ram_rdata, word_q;

  logic [WB-1:0] hint_oh, idx_oh, ffz_oh;
  logic [BW-1:0] ffz_idx;
  logic [CW-1:0] scan_slot;
  logic [CW-1:0] avail_dec, avail_inc;
  logic          release_pg;

  bsa_ram #(
    .WIDTH(WB),
    .DEPTH(bsa_pkg::WORD_COUNT)
  ) u_bitmap (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // A word never written since reset or reconfiguration reads as all free
  assign word_q = rvld_r ? ram_rdata : '0;

  assign hint_oh = {{(WB-1){1'b0}}, 1'b1} << hint_r[BW-1:0];
  assign idx_oh  = {{(WB-1){1'b0}}, 1'b1} << idx_r[BW-1:0];

  // Lowest clear bit of the word just read
  assign ffz_oh = ~word_q & (word_q + {{(WB-1){1'b0}}, 1'b1});

  always_comb begin
    ffz_idx = '0;
    for (int b = 0; b < WB; b++) begin
      if (ffz_oh[b]) begin
        ffz_idx = ffz_idx | BW'(b);
      end
    end
  end

  assign scan_slot = CW'({scan_w_r, ffz_idx});
  assign avail_dec = avail_r - CW'(1);
  assign avail_inc = avail_r + CW'(1);

  // Page empties and is shared with others: release it
  assign release_pg = !(avail_r == '0 && count_r > CW'(1)) && (avail_inc == count_r)
                      && !sole_r;

  // Read address select
  always_comb begin
    case (cmd.rd_sel)
      bsa_pkg::RD_HINT:  rd_addr = hint_r[AW+BW-1:BW];
      bsa_pkg::RD_IDX:   rd_addr = idx_r[AW+BW-1:BW];
      bsa_pkg::RD_SCAN0: rd_addr = '0;
      bsa_pkg::RD_NEXT:  rd_addr = scan_w_r + AW'(1);
      default:           rd_addr = '0;
    endcase
  end

  // Write-back of the modified word
  always_comb begin
    ram_we    = 1'b0;
    wr_addr   = '0;
    ram_wdata = word_q;
    case (cmd.act)
      bsa_pkg::ACT_ALLOC_HINT: begin
        ram_we    = 1'b1;
        wr_addr   = hint_r[AW+BW-1:BW];
        ram_wdata = word_q | hint_oh;
      end
      bsa_pkg::ACT_ALLOC_SCAN: begin
        ram_we    = 1'b1;
        wr_addr   = scan_w_r;
        ram_wdata = word_q | ffz_oh;
      end
      bsa_pkg::ACT_FREE: begin
        ram_we    = 1'b1;
        wr_addr   = idx_r[AW+BW-1:BW];
        ram_wdata = word_q & ~idx_oh;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign ram_addr = ram_we ? wr_addr : rd_addr;

  // Status to the controller
  always_comb begin
    st.op            = op_r;
    st.alloc_blocked = (avail_r == '0) || !alive_r;
    st.range_err     = (idx_r >= count_r);
    st.hint_valid    = hint_valid_r;
    st.hint_in_range = (hint_r < count_r);
    st.bit_used      = (op_r == bsa_pkg::OP_FREE) ? word_q[idx_r[BW-1:0]]
                                                  : word_q[hint_r[BW-1:0]];
    st.word_full     = &word_q;
    st.scan_in_range = (scan_slot < count_r);
    st.scan_last     = (scan_w_r == AW'(bsa_pkg::WORD_COUNT - 1));
  end

  // Page state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= bsa_pkg::eff_count(bsa_pkg::SLOT_COUNT_W'(512));
      avail_r      <= bsa_pkg::eff_count(bsa_pkg::SLOT_COUNT_W'(512));
      hint_r       <= '0;
      hint_valid_r <= 1'b1;
      alive_r      <= 1'b1;
      wvalid_r     <= '0;
      scan_w_r     <= '0;
      rvld_r       <= 1'b0;
    end else if (cfg_wr_en) begin
      count_r      <= bsa_pkg::eff_count(cfg_wr_data);
      avail_r      <= bsa_pkg::eff_count(cfg_wr_data);
      hint_r       <= '0;
      hint_valid_r <= 1'b1;
      alive_r      <= 1'b1;
      wvalid_r     <= '0;
    end else begin
      rvld_r <= wvalid_r[ram_addr];
      if (ram_we) begin
        wvalid_r[wr_addr] <= 1'b1;
      end
      if (cmd.scan_rst) begin
        scan_w_r <= '0;
      end else if (cmd.scan_step) begin
        scan_w_r <= scan_w_r + AW'(1);
      end
      if (cmd.hint_clr) begin
        hint_valid_r <= 1'b0;
      end
      case (cmd.act)
        bsa_pkg::ACT_ALLOC_HINT, bsa_pkg::ACT_ALLOC_SCAN: begin
          avail_r <= avail_dec;
        end
        bsa_pkg::ACT_FREE: begin
          avail_r      <= avail_inc;
          hint_r       <= idx_r;
          hint_valid_r <= 1'b1;
          if (release_pg) begin
            alive_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      idx_r  <= CW'(in_slot_index);
      sole_r <= in_sole_in_list;
    end
  end

  // Result of the transaction
  always_ff @(posedge clk) begin
    case (cmd.act)
      bsa_pkg::ACT_ERR_NOSLOT, bsa_pkg::ACT_ERR_FREE, bsa_pkg::ACT_ERR_RANGE: begin
        res_status_r  <= (cmd.act == bsa_pkg::ACT_ERR_NOSLOT) ? bsa_pkg::ST_NOSLOT :
                         (cmd.act == bsa_pkg::ACT_ERR_FREE)   ? bsa_pkg::ST_DBLFREE :
                                                                bsa_pkg::ST_RANGE;
        res_granted_r <= '0;
        res_keep_r    <= (op_r == bsa_pkg::OP_ALLOC) ? alive_r : 1'b1;
        res_left_r    <= 1'b0;
        res_rejoin_r  <= 1'b0;
        res_free_r    <= avail_r[bsa_pkg::SLOT_COUNT_W-1:0];
      end
      bsa_pkg::ACT_ALLOC_HINT, bsa_pkg::ACT_ALLOC_SCAN: begin
        res_status_r  <= bsa_pkg::ST_OK;
        res_granted_r <= (cmd.act == bsa_pkg::ACT_ALLOC_HINT) ?
                         hint_r[bsa_pkg::SLOT_IDX_W-1:0] :
                         scan_slot[bsa_pkg::SLOT_IDX_W-1:0];
        res_keep_r    <= alive_r;
        res_left_r    <= (avail_dec == '0);
        res_rejoin_r  <= 1'b0;
        res_free_r    <= avail_dec[bsa_pkg::SLOT_COUNT_W-1:0];
      end
      bsa_pkg::ACT_FREE: begin
        res_status_r  <= bsa_pkg::ST_OK;
        res_granted_r <= '0;
        res_keep_r    <= !release_pg;
        res_left_r    <= release_pg;
        res_rejoin_r  <= (avail_r == '0);
        res_free_r    <= avail_inc[bsa_pkg::SLOT_COUNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status_r  <= res_status_r;
      out_granted_r <= res_granted_r;
      out_keep_r    <= res_keep_r;
      out_left_r    <= res_left_r;
      out_rejoin_r  <= res_rejoin_r;
      out_free_r    <= res_free_r;
    end
  end

  assign out_status        = out_status_r;
  assign out_granted_index = out_granted_r;
  assign out_keep_page     = out_keep_r;
  assign out_left_pool     = out_left_r;
  assign out_rejoined_pool = out_rejoin_r;
  assign out_free_count    = out_free_r;

endmodule

// ===== rtl/bsa_ctrl.sv =====
module bsa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  bsa_pkg::bsa_status_t  st,
  output bsa_pkg::bsa_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_HCHK   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FCHK   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // nothing is taken while reset is held
  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.act       = bsa_pkg::ACT_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.op == bsa_pkg::OP_ALLOC) begin
          if (st.alloc_blocked) begin
            cmd.act   = bsa_pkg::ACT_ERR_NOSLOT;
            state_nxt = S_OUT;
          end else if (st.hint_valid && st.hint_in_range) begin
            cmd.hint_clr = 1'b1;
            cmd.rd_sel   = bsa_pkg::RD_HINT;
            state_nxt    = S_HCHK;
          end else begin
            cmd.hint_clr = st.hint_valid;
            cmd.rd_sel   = bsa_pkg::RD_SCAN0;
            cmd.scan_rst = 1'b1;
            state_nxt    = S_SCAN;
          end
        end else begin
          if (st.range_err) begin
            cmd.act   = bsa_pkg::ACT_ERR_RANGE;
            state_nxt = S_OUT;
          end else begin
            cmd.rd_sel = bsa_pkg::RD_IDX;
            state_nxt  = S_FCHK;
          end
        end
      end
      // hinted slot still clear: take it, else fall back to the scan
      S_HCHK: begin
        if (!st.bit_used) begin
          cmd.act   = bsa_pkg::ACT_ALLOC_HINT;
          state_nxt = S_OUT;
        end else begin
          cmd.rd_sel   = bsa_pkg::RD_SCAN0;
          cmd.scan_rst = 1'b1;
          state_nxt    = S_SCAN;
        end
      end
      // one word per cycle, next read issued while checking this one
      S_SCAN: begin
        if (!st.word_full) begin
          cmd.act   = st.scan_in_range ? bsa_pkg::ACT_ALLOC_SCAN : bsa_pkg::ACT_ERR_NOSLOT;
          state_nxt = S_OUT;
        end else if (st.scan_last) begin
          cmd.act   = bsa_pkg::ACT_ERR_NOSLOT;
          state_nxt = S_OUT;
        end else begin
          cmd.rd_sel    = bsa_pkg::RD_NEXT;
          cmd.scan_step = 1'b1;
        end
      end
      S_FCHK: begin
        cmd.act   = st.bit_used ? bsa_pkg::ACT_FREE : bsa_pkg::ACT_ERR_FREE;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output transaction valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/bitmap_slot_allocator.sv =====
// Bitmap slot allocator for one slab page: up to 512 slots tracked 64 per bitmap
// word in a single-port RAM. Requests are handled one at a time; in_stall is low
// only while the sequencer is idle and out of reset, and a finished result sits in
// the output register so the next transaction is taken while it waits. A request
// refused at once (index out of range, full or dead page) reads no bitmap word; a
// free (double free included) or a hinted allocate reads one, and an allocate that
// scans reads up to all 8 bitmap words in turn (after a stale hint is checked
// first, if there is one). The scan, which reads one RAM word per cycle, sets the
// worst case. A write to cfg_wr_data resets the page without a clearing pass
// (per-word valid flags) and must only be issued while the block is idle.
module bitmap_slot_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [bsa_pkg::SLOT_COUNT_W-1:0] cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [bsa_pkg::SLOT_IDX_W-1:0]   in_slot_index,
  input  logic                             in_sole_in_list,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bsa_pkg::STATUS_W-1:0]     out_status,
  output logic [bsa_pkg::SLOT_IDX_W-1:0]   out_granted_index,
  output logic                             out_keep_page,
  output logic                             out_left_pool,
  output logic                             out_rejoined_pool,
  output logic [bsa_pkg::SLOT_COUNT_W-1:0] out_free_count
);

  bsa_pkg::bsa_cmd_t    cmd;
  bsa_pkg::bsa_status_t st;

  // Sequencer
  bsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Bitmap, counters and result registers
  bsa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_op            (in_op),
    .in_slot_index    (in_slot_index),
    .in_sole_in_list  (in_sole_in_list),
    .cmd              (cmd),
    .st               (st),
    .out_status       (out_status),
    .out_granted_index(out_granted_index),
    .out_keep_page    (out_keep_page),
    .out_left_pool    (out_left_pool),
    .out_rejoined_pool(out_rejoined_pool),
    .out_free_count   (out_free_count)
  );

endmodule
